>>> hw/rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion converter.
// No dependencies.
package rmq_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = DATA_WIDTH - 2;
	localparam int ARG_WIDTH  = DATA_WIDTH + 2;
	localparam int QDEPTH     = 4;

	typedef enum logic [1:0] {
		CASE_W = 2'd0,
		CASE_X = 2'd1,
		CASE_Y = 2'd2,
		CASE_Z = 2'd3
	} case_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] r00;
		logic signed [DATA_WIDTH-1:0] r01;
		logic signed [DATA_WIDTH-1:0] r02;
		logic signed [DATA_WIDTH-1:0] r10;
		logic signed [DATA_WIDTH-1:0] r11;
		logic signed [DATA_WIDTH-1:0] r12;
		logic signed [DATA_WIDTH-1:0] r20;
		logic signed [DATA_WIDTH-1:0] r21;
		logic signed [DATA_WIDTH-1:0] r22;
	} in_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] quat_w;
		logic signed [DATA_WIDTH-1:0] quat_x;
		logic signed [DATA_WIDTH-1:0] quat_y;
		logic signed [DATA_WIDTH-1:0] quat_z;
		logic [1:0]                   dominant_case;
	} out_t;

	// classified request: radicand and the three off-dominant numerators
	typedef struct packed {
		case_t                    sel;
		logic [ARG_WIDTH-1:0]     arg;
		logic [2:0][DATA_WIDTH:0] n;
	} work_t;

endpackage

>>> hw/rtl/rmq_front.sv
// Front end: trace test, case select, radicand and numerators, one register stage.
// Depends on rmq_pkg.
module rmq_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  rmq_pkg::in_t  item,
	output logic          wr,
	input  logic          q_full,
	output rmq_pkg::work_t work
);
	import rmq_pkg::*;

	localparam int EW = DATA_WIDTH + 3;
	localparam int W1 = DATA_WIDTH + 1;

	logic signed [EW-1:0] e00, e11, e22, tr, arg_s, one;
	logic signed [W1-1:0] d_w, d_y, d_z, s_xy, s_xz, s_yz;
	work_t wk;
	work_t work_s1;
	logic  vld_s1;
	logic  accept;

	always_comb begin
		one  = EW'(1) <<< FRAC_BITS;
		e00  = EW'(item.r00);
		e11  = EW'(item.r11);
		e22  = EW'(item.r22);
		tr   = e00 + e11 + e22;
		d_w  = W1'(item.r21) - W1'(item.r12);
		d_y  = W1'(item.r02) - W1'(item.r20);
		d_z  = W1'(item.r10) - W1'(item.r01);
		s_xy = W1'(item.r01) + W1'(item.r10);
		s_xz = W1'(item.r02) + W1'(item.r20);
		s_yz = W1'(item.r12) + W1'(item.r21);
		priority if (tr > 0) begin
			wk.sel = CASE_W;
			arg_s  = one + tr;
			wk.n   = {d_z, d_y, d_w};
		end else if (e00 > e11 && e00 > e22) begin
			wk.sel = CASE_X;
			arg_s  = one + e00 - e11 - e22;
			wk.n   = {s_xz, s_xy, d_w};
		end else if (e11 > e22) begin
			wk.sel = CASE_Y;
			arg_s  = one + e11 - e00 - e22;
			wk.n   = {s_yz, s_xy, d_y};
		end else begin
			wk.sel = CASE_Z;
			arg_s  = one + e22 - e00 - e11;
			wk.n   = {s_yz, s_xz, d_z};
		end
		wk.arg = arg_s[EW-1] ? '0 : arg_s[ARG_WIDTH-1:0];
	end

	assign full   = vld_s1 && q_full;
	assign accept = push && !full;
	assign wr     = vld_s1 && !q_full;
	assign work   = work_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept || full;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_s1 <= wk;
		end
	end

endmodule

>>> hw/rtl/rmq_fifo.sv
// Short request queue between front and back ends.
// Depends on rmq_pkg.
module rmq_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  rmq_pkg::work_t din,
	input  logic           pop,
	output logic           empty,
	output rmq_pkg::work_t dout
);
	import rmq_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	work_t         mem_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic          do_wr, do_rd;

	assign full  = cnt_q == (PW+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rp_q];
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(do_wr) - (PW+1)'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule

>>> hw/rtl/rmq_back.sv
// Back end: pipelined square root, pipelined dividers, saturation, output register.
// Depends on rmq_pkg.
module rmq_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  rmq_pkg::work_t work,
	output logic           q_pop,
	output logic           empty,
	input  logic           pop,
	output rmq_pkg::out_t  result
);
	import rmq_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int RW = 2 * W;

	typedef struct packed {
		work_t         wk;
		logic [W+1:0]  rem;
		logic [W-1:0]  root;
		logic [RW-1:0] rad;
	} sq_t;

	typedef struct packed {
		case_t               sel;
		logic [W-1:0]        dom;
		logic                zero;
		logic [2:0]          neg;
		logic [2:0]          ovf;
		logic [2:0][RW-1:0]  rem;
		logic [2:0][W-1:0]   q;
		logic [W:0]          dvs;
	} dv_t;

	function automatic sq_t sq_step(sq_t s);
		logic [W+3:0] cur, trl;
		sq_t o;
		o   = s;
		cur = {s.rem, s.rad[RW-1 -: 2]};
		trl = {2'b00, s.root, 2'b01};
		if (cur >= trl) begin
			o.rem  = (W+2)'(cur - trl);
			o.root = {s.root[W-2:0], 1'b1};
		end else begin
			o.rem  = cur[W+1:0];
			o.root = {s.root[W-2:0], 1'b0};
		end
		o.rad = {s.rad[RW-3:0], 2'b00};
		return o;
	endfunction

	function automatic dv_t dv_prep(sq_t s);
		logic signed [W:0] nk;
		logic [W:0]        m;
		logic [W:0]        r1;
		dv_t o;
		o      = '0;
		o.sel  = s.wk.sel;
		o.dvs  = {s.root, 1'b0};
		o.zero = s.root == '0;
		r1     = (W+1)'(s.root) + 1'b1;
		o.dom  = r1[W:1];
		for (int k = 0; k < 3; k++) begin
			nk       = $signed(s.wk.n[k]);
			o.neg[k] = nk[W];
			m        = nk[W] ? (W+1)'(-nk) : nk;
			o.rem[k] = RW'({m, {FRAC_BITS{1'b0}}}) + RW'(s.root);
			o.ovf[k] = {1'b0, o.rem[k]} >= {o.dvs, {W{1'b0}}};
		end
		return o;
	endfunction

	function automatic dv_t dv_step(dv_t s, int b);
		logic [RW:0] d;
		dv_t o;
		o = s;
		d = (RW+1)'(s.dvs) << b;
		for (int k = 0; k < 3; k++) begin
			if ({1'b0, s.rem[k]} >= d) begin
				o.rem[k]  = RW'({1'b0, s.rem[k]} - d);
				o.q[k][b] = 1'b1;
			end else begin
				o.q[k][b] = 1'b0;
			end
		end
		return o;
	endfunction

	function automatic logic [W-1:0] sat_q(dv_t s, int k);
		logic [W-1:0] mx, mn;
		mx = {1'b0, {(W-1){1'b1}}};
		mn = {1'b1, {(W-1){1'b0}}};
		if (s.zero) return '0;
		if (s.neg[k]) begin
			if (s.ovf[k] || s.q[k] > mn) return mn;
			return W'(-s.q[k]);
		end
		if (s.ovf[k] || s.q[k] > mx) return mx;
		return s.q[k];
	endfunction

	sq_t  sq_s [W];
	logic sq_v [W];
	dv_t  dv_s [W+1];
	logic dv_v [W+1];
	out_t out_q;
	logic out_v_q;
	logic en;
	sq_t  sq_in;
	out_t res;
	logic [W-1:0] dq;
	logic [2:0][W-1:0] oq;

	assign en     = !out_v_q || pop;
	assign q_pop  = en;
	assign empty  = !out_v_q;
	assign result = out_q;

	always_comb begin
		sq_in      = '0;
		sq_in.wk   = work;
		sq_in.rad  = {work.arg, {FRAC_BITS{1'b0}}};
	end

	for (genvar i = 0; i < W; i++) begin : g_sq
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[i] <= 1'b0;
			end else if (en) begin
				sq_v[i] <= (i == 0) ? !q_empty : sq_v[(i == 0) ? 0 : i-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[i] <= sq_step((i == 0) ? sq_in : sq_s[(i == 0) ? 0 : i-1]);
			end
		end
	end

	for (genvar j = 0; j <= W; j++) begin : g_dv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j] <= 1'b0;
			end else if (en) begin
				dv_v[j] <= (j == 0) ? sq_v[W-1] : dv_v[(j == 0) ? 0 : j-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (j == 0) begin
					dv_s[j] <= dv_prep(sq_s[W-1]);
				end else begin
					dv_s[j] <= dv_step(dv_s[(j == 0) ? 0 : j-1], W - j);
				end
			end
		end
	end

	always_comb begin
		dq    = dv_s[W].dom[W-1] ? {1'b0, {(W-1){1'b1}}} : dv_s[W].dom;
		oq[0] = sat_q(dv_s[W], 0);
		oq[1] = sat_q(dv_s[W], 1);
		oq[2] = sat_q(dv_s[W], 2);
		res.dominant_case = dv_s[W].sel;
		unique case (dv_s[W].sel)
			CASE_W: begin
				{res.quat_w, res.quat_x, res.quat_y, res.quat_z} = {dq, oq[0], oq[1], oq[2]};
			end
			CASE_X: begin
				{res.quat_w, res.quat_x, res.quat_y, res.quat_z} = {oq[0], dq, oq[1], oq[2]};
			end
			CASE_Y: begin
				{res.quat_w, res.quat_x, res.quat_y, res.quat_z} = {oq[0], oq[1], dq, oq[2]};
			end
			default: begin
				{res.quat_w, res.quat_x, res.quat_y, res.quat_z} = {oq[0], oq[1], oq[2], dq};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_v[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= res;
		end
	end

endmodule

>>> hw/rtl/rotation_matrix_to_quaternion.sv
// Top level of the rotation matrix to quaternion converter.
// Depends on rmq_pkg, rmq_front, rmq_fifo, rmq_back.
//
// Converts one Q2.14 rotation matrix per request into a saturated Q2.14 quaternion
// (trace method) plus the branch used. One request per cycle is accepted while full
// is low, and one result per cycle is delivered while pop is held. The classify
// register loads at the accept edge; from there a request passes through the queue,
// a DATA_WIDTH-stage square root, one divider setup stage, DATA_WIDTH divider stages
// of one quotient bit each, and the output register. A 4-entry queue sits between
// classifier and the arithmetic pipeline, which freezes as a whole while its result
// is not taken.
module rotation_matrix_to_quaternion (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  rmq_pkg::in_t  item,
	output logic          empty,
	input  logic          pop,
	output rmq_pkg::out_t result
);
	import rmq_pkg::*;

	work_t f_work, q_work;
	logic  f_wr, q_full, q_empty, q_pop;

	rmq_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.wr     (f_wr),
		.q_full (q_full),
		.work   (f_work)
	);

	rmq_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_wr),
		.full   (q_full),
		.din    (f_work),
		.pop    (q_pop),
		.empty  (q_empty),
		.dout   (q_work)
	);

	rmq_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.work    (q_work),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

>>> hw/rtl/rmq_checker.sv
// Port-level checks for rotation_matrix_to_quaternion, bound to the top level.
// Depends on rmq_pkg.
module rmq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          empty,
	input logic          pop,
	input rmq_pkg::out_t result
);
	import rmq_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while waiting");

	a_w_dom: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.dominant_case == CASE_W |-> result.quat_w >= 0)
		else $error("w dominant but negative");

	a_xyz_dom: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.dominant_case == CASE_X && result.quat_x >= 0) ||
		           (result.dominant_case == CASE_Y && result.quat_y >= 0) ||
		           (result.dominant_case == CASE_Z && result.quat_z >= 0) ||
		           (result.dominant_case == CASE_W))
		else $error("dominant component negative");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
